[design/mtr_pkg.sv]
// Package for the multipole tensor rotation core: beat types, widths,
// pass and output schedules and the full-to-packed index tables.
// No dependencies.
`timescale 1ns / 1ps

package mtr_pkg;

	localparam int WW    = 42;
	localparam int AW    = 77;
	localparam int XW    = 48;
	localparam int TW    = 44;
	localparam int SAT_W = 32;

	typedef enum logic [2:0] {
		K_LOAD_ROT = 3'd0,
		K_LOAD_MP  = 3'd1,
		K_ROT_MP   = 3'd2,
		K_LOAD_POL = 3'd3,
		K_ROT_POL  = 3'd4
	} mtr_kind_t;

	typedef struct packed {
		logic [2:0]         kind;
		logic [4:0]         slot;
		logic signed [31:0] value;
	} mtr_cmd_t;

	typedef struct packed {
		logic               set_kind;
		logic [4:0]         slot_out;
		logic signed [31:0] result_value;
		logic               last;
	} mtr_res_t;

	typedef struct packed {
		logic first;
		logic add;
	} mtr_mac_ctl_t;

	typedef enum logic [1:0] {ST_IDLE, ST_PASS, ST_OUT} mtr_state_t;
	typedef enum logic [1:0] {SM_WORK, SM_DIRECT, SM_QUAD, SM_OCT} mtr_src_t;
	typedef enum logic [1:0] {N3, N9, N27} mtr_len_t;
	typedef enum logic [1:0] {TM_NONE, TM_QUAD, TM_OCT} mtr_trace_t;
	typedef enum logic [2:0] {TR_NONE, TR_Q, TR_X, TR_Y, TR_Z} mtr_trsel_t;
	typedef enum logic [1:0] {F_PLAIN, F_QUAD, F_OCT} mtr_form_t;

	localparam logic [2:0] PASS_DIP   = 3'd0;
	localparam logic [2:0] PASS_Q0    = 3'd1;
	localparam logic [2:0] PASS_Q1    = 3'd2;
	localparam logic [2:0] PASS_O0    = 3'd3;
	localparam logic [2:0] PASS_O1    = 3'd4;
	localparam logic [2:0] PASS_O2    = 3'd5;
	localparam logic [2:0] PASS_P0    = 3'd6;
	localparam logic [2:0] PASS_P1    = 3'd7;

	localparam logic [4:0] POL_BASE   = 5'd19;
	localparam logic [4:0] MP_SLOTS   = 5'd19;
	localparam logic [4:0] MAT_SLOTS  = 5'd9;
	localparam logic [4:0] MP_LAST    = 5'd18;
	localparam logic [4:0] POL_LAST   = 5'd8;

	localparam logic [6:0] R0 = 7'd0;
	localparam logic [6:0] R1 = 7'd32;
	localparam logic [6:0] R2 = 7'd64;
	localparam logic [6:0] R3 = 7'd96;
	localparam logic [6:0] RQ = 7'd112;

	typedef struct packed {
		mtr_src_t   src;
		logic [6:0] src_base;
		logic [4:0] in_base;
		logic [6:0] dst_base;
		mtr_len_t   len;
		logic [1:0] axis;
		mtr_trace_t trace;
	} mtr_pass_t;

	typedef struct packed {
		logic [6:0] addr;
		mtr_form_t  form;
		mtr_trsel_t trsel;
		logic       tr3;
	} mtr_out_t;

	function automatic mtr_pass_t pass_info(input logic [2:0] p);
		mtr_pass_t r;
		r = '{SM_WORK, R0, 5'd0, R0, N9, 2'd0, TM_NONE};
		case (p)
			PASS_DIP: r = '{SM_DIRECT, R0, 5'd0, R3, N3, 2'd0, TM_NONE};
			PASS_Q0:  r = '{SM_QUAD, R0, 5'd0, R0, N9, 2'd0, TM_NONE};
			PASS_Q1:  r = '{SM_WORK, R0, 5'd0, RQ, N9, 2'd1, TM_QUAD};
			PASS_O0:  r = '{SM_OCT, R0, 5'd0, R0, N27, 2'd0, TM_NONE};
			PASS_O1:  r = '{SM_WORK, R0, 5'd0, R1, N27, 2'd1, TM_NONE};
			PASS_O2:  r = '{SM_WORK, R1, 5'd0, R2, N27, 2'd2, TM_OCT};
			PASS_P0:  r = '{SM_DIRECT, R0, POL_BASE, R0, N9, 2'd0, TM_NONE};
			PASS_P1:  r = '{SM_WORK, R0, 5'd0, R1, N9, 2'd1, TM_NONE};
			default:  r = '{SM_WORK, R0, 5'd0, R0, N9, 2'd0, TM_NONE};
		endcase
		return r;
	endfunction

	function automatic logic [4:0] qmap(input logic [4:0] i);
		logic [4:0] s;
		case (i)
			5'd0:    s = 5'd3;
			5'd1:    s = 5'd6;
			5'd2:    s = 5'd7;
			5'd3:    s = 5'd6;
			5'd4:    s = 5'd4;
			5'd5:    s = 5'd8;
			5'd6:    s = 5'd7;
			5'd7:    s = 5'd8;
			5'd8:    s = 5'd5;
			default: s = 5'd3;
		endcase
		return s;
	endfunction

	function automatic logic [4:0] omap(input logic [4:0] i);
		logic [4:0] s;
		case (i)
			5'd0:                                   s = 5'd9;
			5'd13:                                  s = 5'd10;
			5'd26:                                  s = 5'd11;
			5'd1, 5'd3, 5'd9:                       s = 5'd12;
			5'd2, 5'd6, 5'd18:                      s = 5'd13;
			5'd4, 5'd10, 5'd12:                     s = 5'd14;
			5'd14, 5'd16, 5'd22:                    s = 5'd15;
			5'd8, 5'd20, 5'd24:                     s = 5'd16;
			5'd17, 5'd23, 5'd25:                    s = 5'd17;
			default:                                s = 5'd18;
		endcase
		return s;
	endfunction

	function automatic mtr_out_t out_info(input logic pol, input logic [4:0] j);
		mtr_out_t o;
		o = '{R1 + 7'(j), F_PLAIN, TR_NONE, 1'b0};
		if (!pol) begin
			case (j)
				5'd0, 5'd1, 5'd2: o = '{R3 + 7'(j), F_PLAIN, TR_NONE, 1'b0};
				5'd3:  o = '{RQ + 7'd0, F_QUAD, TR_Q, 1'b0};
				5'd4:  o = '{RQ + 7'd4, F_QUAD, TR_Q, 1'b0};
				5'd5:  o = '{RQ + 7'd8, F_QUAD, TR_Q, 1'b0};
				5'd6:  o = '{RQ + 7'd1, F_QUAD, TR_NONE, 1'b0};
				5'd7:  o = '{RQ + 7'd2, F_QUAD, TR_NONE, 1'b0};
				5'd8:  o = '{RQ + 7'd5, F_QUAD, TR_NONE, 1'b0};
				5'd9:  o = '{R2 + 7'd0, F_OCT, TR_X, 1'b1};
				5'd10: o = '{R2 + 7'd13, F_OCT, TR_Y, 1'b1};
				5'd11: o = '{R2 + 7'd26, F_OCT, TR_Z, 1'b1};
				5'd12: o = '{R2 + 7'd1, F_OCT, TR_Y, 1'b0};
				5'd13: o = '{R2 + 7'd2, F_OCT, TR_Z, 1'b0};
				5'd14: o = '{R2 + 7'd4, F_OCT, TR_X, 1'b0};
				5'd15: o = '{R2 + 7'd14, F_OCT, TR_Z, 1'b0};
				5'd16: o = '{R2 + 7'd8, F_OCT, TR_X, 1'b0};
				5'd17: o = '{R2 + 7'd17, F_OCT, TR_Y, 1'b0};
				default: o = '{R2 + 7'd5, F_OCT, TR_NONE, 1'b0};
			endcase
		end
		return o;
	endfunction

	function automatic logic [4:0] lin(input logic [1:0] d2, input logic [1:0] d1,
			input logic [1:0] d0);
		return 5'(d2) * 5'd9 + 5'(d1) * 5'd3 + 5'(d0);
	endfunction

	function automatic logic signed [31:0] sat32(input logic signed [XW-1:0] x);
		logic signed [XW-1:0] mx;
		logic signed [XW-1:0] mn;
		mx = XW'(signed'({1'b0, {(SAT_W-1){1'b1}}}));
		mn = -mx - XW'(1);
		if (x > mx)
			return mx[31:0];
		else if (x < mn)
			return mn[31:0];
		return x[31:0];
	endfunction

endpackage

[design/multipole_tensor_rotation_core.sv]
// Top level of the multipole tensor rotation core: command decode, pass
// sequencer, working memory, corrections and the result register.
// Depends on mtr_pkg and mtr_mac.
`timescale 1ns / 1ps

// Use: a beat on cmd is taken when start is high and busy is low. Loads of
// the rotation matrix, multipoles and polarizability may follow one another
// in every cycle; they produce no result. A rotate command raises busy and
// walks the tensors through the working memory element by element, in a
// single shared multiply-accumulate unit (three reads of the memory port,
// one product per read). A multipole rotate does 102 elements and then
// emits its 19 components; a polarizability rotate does 18 elements and
// emits 9 elements. Each result is on result for one cycle with strobe
// high, and last marks the final one; busy falls in that cycle.
// The receiver cannot hold results off, so none is ever held back.
// Reset clears only the sequencer; loaded values are undefined until written.
module multipole_tensor_rotation_core (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  mtr_pkg::mtr_cmd_t cmd,
	output logic              strobe,
	output mtr_pkg::mtr_res_t result
);
	import mtr_pkg::*;

	mtr_state_t state_q, state_d;
	logic [2:0]  pass_q;
	logic [2:0]  step_q;
	logic [1:0]  dg_q [3];
	logic        is_pol_q;
	logic [4:0]  oj_q;
	logic        ost_q;
	logic        strobe_q;
	mtr_res_t    res_q;

	logic signed [31:0]   rot_q [3][3];
	logic signed [31:0]   in_mem [32];
	logic signed [31:0]   ird_q;
	logic signed [WW-1:0] work_mem [128];
	logic signed [WW-1:0] wrd_q;
	logic signed [TW-1:0] trq_q, trx_q, try_q, trz_q;

	mtr_pass_t            pinfo;
	mtr_out_t             oinfo;
	mtr_mac_ctl_t         mctl;
	logic [1:0]           sd [3];
	logic [1:0]           k_rd, k_mul, row;
	logic [4:0]           src_idx, elem_idx;
	logic [6:0]           w_raddr, w_waddr;
	logic [4:0]           i_raddr;
	logic                 w_wen, elem_last, pass_final, out_last, accept;
	logic signed [WW-1:0] a_val, rnd;
	logic signed [31:0]   r_val;
	logic signed [XW-1:0] v_x, tr_x, trm, x_c, h_x;

	assign accept = start && !busy;
	assign pinfo  = pass_info(pass_q);
	assign oinfo  = out_info(is_pol_q, oj_q);
	assign row    = dg_q[pinfo.axis];
	assign k_rd   = step_q[1:0];
	assign k_mul  = 2'(step_q - 3'd1);

	always_comb begin
		sd = dg_q;
		sd[pinfo.axis] = k_rd;
	end

	assign src_idx  = lin(sd[2], sd[1], sd[0]);
	assign elem_idx = lin(dg_q[2], dg_q[1], dg_q[0]);
	assign elem_last = (dg_q[0] == 2'd2) && (pinfo.len == N3 || dg_q[1] == 2'd2)
		&& (pinfo.len != N27 || dg_q[2] == 2'd2);
	assign pass_final = (pass_q == PASS_O2) || (pass_q == PASS_P1);
	assign out_last   = is_pol_q ? (oj_q == POL_LAST) : (oj_q == MP_LAST);

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept && (cmd.kind == K_ROT_MP || cmd.kind == K_ROT_POL))
					state_d = ST_PASS;
			end
			ST_PASS: begin
				if (step_q == 3'd5 && elem_last && pass_final)
					state_d = ST_OUT;
			end
			ST_OUT: begin
				if (ost_q && out_last)
					state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		busy     = (state_q != ST_IDLE);
		w_wen    = (state_q == ST_PASS) && (step_q == 3'd5);
		w_waddr  = pinfo.dst_base + 7'(elem_idx);
		w_raddr  = (state_q == ST_OUT) ? oinfo.addr : pinfo.src_base + 7'(src_idx);
		mctl.first = (state_q == ST_PASS) && (step_q == 3'd2);
		mctl.add   = (state_q == ST_PASS) && (step_q == 3'd3 || step_q == 3'd4);
		case (pinfo.src)
			SM_QUAD: i_raddr = qmap(src_idx);
			SM_OCT:  i_raddr = omap(src_idx);
			default: i_raddr = pinfo.in_base + src_idx;
		endcase
	end

	assign a_val = (pinfo.src == SM_WORK) ? wrd_q : WW'(ird_q);
	assign r_val = rot_q[row][k_mul];

	mtr_mac u_mac (
		.clk (clk),
		.ctl (mctl),
		.a   (a_val),
		.r   (r_val),
		.rnd (rnd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			pass_q   <= PASS_DIP;
			step_q   <= 3'd0;
			dg_q     <= '{2'd0, 2'd0, 2'd0};
			is_pol_q <= 1'b0;
			oj_q     <= 5'd0;
			ost_q    <= 1'b0;
			strobe_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			strobe_q <= (state_q == ST_OUT) && ost_q;
			case (state_q)
				ST_IDLE: begin
					is_pol_q <= (cmd.kind == K_ROT_POL);
					pass_q   <= (cmd.kind == K_ROT_POL) ? PASS_P0 : PASS_DIP;
					step_q   <= 3'd0;
					dg_q     <= '{2'd0, 2'd0, 2'd0};
					oj_q     <= 5'd0;
					ost_q    <= 1'b0;
				end
				ST_PASS: begin
					if (step_q == 3'd5) begin
						step_q <= 3'd0;
						if (elem_last) begin
							dg_q   <= '{2'd0, 2'd0, 2'd0};
							pass_q <= pass_q + 3'd1;
						end else if (dg_q[0] != 2'd2) begin
							dg_q[0] <= dg_q[0] + 2'd1;
						end else if (dg_q[1] != 2'd2) begin
							dg_q[0] <= 2'd0;
							dg_q[1] <= dg_q[1] + 2'd1;
						end else begin
							dg_q[0] <= 2'd0;
							dg_q[1] <= 2'd0;
							dg_q[2] <= dg_q[2] + 2'd1;
						end
					end else begin
						step_q <= step_q + 3'd1;
					end
				end
				ST_OUT: begin
					ost_q <= !ost_q;
					if (ost_q)
						oj_q <= oj_q + 5'd1;
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept && state_q == ST_IDLE) begin
			trq_q <= '0;
			trx_q <= '0;
			try_q <= '0;
			trz_q <= '0;
		end else if (w_wen) begin
			if (pinfo.trace == TM_QUAD && (elem_idx == 5'd0 || elem_idx == 5'd4
					|| elem_idx == 5'd8))
				trq_q <= trq_q + TW'(rnd);
			if (pinfo.trace == TM_OCT) begin
				case (elem_idx) inside
					5'd0, 5'd4, 5'd8:    trx_q <= trx_q + TW'(rnd);
					5'd3, 5'd13, 5'd23:  try_q <= try_q + TW'(rnd);
					5'd2, 5'd14, 5'd26:  trz_q <= trz_q + TW'(rnd);
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && cmd.kind == K_LOAD_ROT && cmd.slot < MAT_SLOTS) begin
			if (cmd.slot < 5'd3)
				rot_q[0][2'(cmd.slot)] <= cmd.value;
			else if (cmd.slot < 5'd6)
				rot_q[1][2'(cmd.slot - 5'd3)] <= cmd.value;
			else
				rot_q[2][2'(cmd.slot - 5'd6)] <= cmd.value;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && cmd.kind == K_LOAD_MP && cmd.slot < MP_SLOTS)
			in_mem[cmd.slot] <= cmd.value;
		else if (accept && cmd.kind == K_LOAD_POL && cmd.slot < MAT_SLOTS)
			in_mem[POL_BASE + cmd.slot] <= cmd.value;
		ird_q <= in_mem[i_raddr];
	end

	always_ff @(posedge clk) begin
		if (w_wen)
			work_mem[w_waddr] <= rnd;
		wrd_q <= work_mem[w_raddr];
	end

	always_comb begin
		v_x = XW'(wrd_q);
		case (oinfo.trsel)
			TR_Q:    tr_x = XW'(trq_q);
			TR_X:    tr_x = XW'(trx_q);
			TR_Y:    tr_x = XW'(try_q);
			TR_Z:    tr_x = XW'(trz_q);
			default: tr_x = '0;
		endcase
		trm = oinfo.tr3 ? (tr_x <<< 1) + tr_x : tr_x;
		case (oinfo.form)
			F_QUAD:  x_c = (v_x <<< 1) + v_x - trm;
			F_OCT:   x_c = (v_x <<< 2) + v_x - trm;
			default: x_c = '0;
		endcase
		h_x = (oinfo.form == F_PLAIN) ? v_x : ((x_c + XW'(1)) >>> 1);
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_OUT && ost_q) begin
			res_q.set_kind     <= is_pol_q;
			res_q.slot_out     <= oj_q;
			res_q.result_value <= sat32(h_x);
			res_q.last         <= out_last;
		end
	end

	assign strobe = strobe_q;
	assign result = res_q;

	a_strobe_from_out: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> $past(state_q == ST_OUT))
		else $error("result beat outside the output phase");
	a_last_ends_run: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && result.last) |-> (state_q == ST_IDLE))
		else $error("final beat while still busy");
	a_step_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_PASS) |-> (step_q <= 3'd5))
		else $error("element step out of range");
	a_pass_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_PASS && !is_pol_q) |-> (pass_q <= PASS_O2))
		else $error("multipole run entered a polarizability pass");

endmodule

[design/mtr_mac.sv]
// Three-term multiply-accumulate of tensor elements by rotation entries,
// with a split 16-bit low product and rounding by 30 bits, half up.
// Depends on mtr_pkg.
`timescale 1ns / 1ps

module mtr_mac (
	input  logic                         clk,
	input  mtr_pkg::mtr_mac_ctl_t        ctl,
	input  logic signed [mtr_pkg::WW-1:0] a,
	input  logic signed [31:0]           r,
	output logic signed [mtr_pkg::WW-1:0] rnd
);
	import mtr_pkg::*;

	logic signed [16:0]      lo_w;
	logic signed [WW-17:0]   hi_w;
	logic signed [48:0]      p_lo_s2;
	logic signed [WW+15:0]   p_hi_s2;
	logic signed [AW-1:0]    term;
	logic signed [AW-1:0]    acc_q;
	logic signed [AW-1:0]    sum;

	assign lo_w = signed'({1'b0, a[15:0]});
	assign hi_w = a[WW-1:16];

	always_ff @(posedge clk) begin
		p_lo_s2 <= lo_w * r;
		p_hi_s2 <= hi_w * r;
		if (ctl.first)
			acc_q <= term;
		else if (ctl.add)
			acc_q <= acc_q + term;
	end

	assign term = (AW'(p_hi_s2) <<< 16) + AW'(p_lo_s2);
	assign sum  = acc_q + signed'({{(AW-30){1'b0}}, 1'b1, 29'd0});
	assign rnd  = sum[30+WW-1:30];

endmodule
